@@ hw/rtl/alld_pkg.sv @@
// ----------------------------------------------------------------------------
// alld_pkg: shared types and constants for the linked-list byte deque
// Holds the transaction payload types, opcode and status codes, and the
// command and status groups exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package alld_pkg;

  // Default number of list nodes.
  localparam int DEPTH_DEF = 64;

  // Fixed payload field widths.
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_FRONT  = 2'd1;
  localparam logic [OP_W-1:0] OP_BACK   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] data_in;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
  } out_item_t;

  // Datapath actions requested by the controller, at most one per cycle.
  typedef struct packed {
    logic accept;
    logic app_link;
    logic walk;
    logic back_fix;
    logic front;
    logic emit;
  } dp_cmd_t;

  // Datapath conditions that steer the controller.
  typedef struct packed {
    logic [OP_W-1:0] op_in;
    logic            direct;
    logic            op_append;
    logic            head_null;
    logic            link_null;
    logic            pred_null;
    logic            out_free;
  } dp_sts_t;

endpackage

@@ hw/rtl/alld_datapath.sv @@
// ----------------------------------------------------------------------------
// alld_datapath: node memories, list pointers and result register
// Keeps the data and link memories, the head, free-head and count
// registers, the chain walk pointers, and the output register. It carries
// out whatever single action the controller asks for in a cycle.
// ----------------------------------------------------------------------------
module alld_datapath
  import alld_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [IW-1:0] NULL_IDX = IW'(DEPTH);
  localparam logic [IW-1:0] ONE_IDX  = IW'(1);

  // Node memories. Link entries at or above the fill mark were never
  // written and are read back as their implied reset link, which is their index plus one.
  logic [IW-1:0]     link_mem [DEPTH];
  logic [BYTE_W-1:0] data_mem [DEPTH];

  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     free_r, free_nxt;
  logic [IW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     fill_r, fill_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     pred_r, pred_nxt;
  logic [IW-1:0]     new_r, new_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [BYTE_W-1:0] pend_data_r, pend_data_nxt;
  logic [STAT_W-1:0] pend_status_r, pend_status_nxt;
  logic [IW-1:0]     rd_addr_r;
  logic              rd_fresh_r;
  logic [IW-1:0]     link_q_r;
  logic [BYTE_W-1:0] data_q_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_link_en;
  logic [IW-1:0]     wr_link_addr;
  logic [IW-1:0]     wr_link_val;
  logic              wr_data_en;
  logic [IW-1:0]     link_raw;
  logic              link_null;
  logic [IW-1:0]     link_eff;
  logic              is_full;
  logic              is_empty;

  // Link read back from the last memory read, with untouched entries
  // replaced by their reset link and out-of-range values taken as null.
  assign link_raw  = rd_fresh_r ? (rd_addr_r + ONE_IDX) : link_q_r;
  assign link_null = (link_raw >= NULL_IDX);
  assign link_eff  = link_null ? NULL_IDX : link_raw;

  assign is_full  = (count_r >= NULL_IDX) || (free_r >= NULL_IDX);
  assign is_empty = (count_r == '0) || (head_r >= NULL_IDX);

  // Status toward the controller.
  always_comb begin
    sts.op_in     = in_data.opcode;
    sts.direct    = (in_data.opcode == OP_NONE) ||
                    ((in_data.opcode == OP_APPEND) && is_full) ||
                    ((in_data.opcode == OP_FRONT || in_data.opcode == OP_BACK) && is_empty);
    sts.op_append = (op_r == OP_APPEND);
    sts.head_null = (head_r >= NULL_IDX);
    sts.link_null = link_null;
    sts.pred_null = (pred_r >= NULL_IDX);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // Action decode.
  always_comb begin
    head_nxt        = head_r;
    free_nxt        = free_r;
    count_nxt       = count_r;
    cur_nxt         = cur_r;
    pred_nxt        = pred_r;
    new_nxt         = new_r;
    op_nxt          = op_r;
    byte_nxt        = byte_r;
    pend_data_nxt   = pend_data_r;
    pend_status_nxt = pend_status_r;
    rd_en           = 1'b0;
    rd_addr         = head_r;
    wr_link_en      = 1'b0;
    wr_link_addr    = cur_r;
    wr_link_val     = NULL_IDX;
    wr_data_en      = 1'b0;

    if (cmd.accept) begin
      // Latch the transaction, judge errors and fetch the first node.
      op_nxt        = in_data.opcode;
      byte_nxt      = in_data.data_in;
      pend_data_nxt = '0;
      pend_status_nxt = ST_OK;
      if (in_data.opcode == OP_APPEND && is_full) begin
        pend_status_nxt = ST_FULL;
      end else if ((in_data.opcode == OP_FRONT || in_data.opcode == OP_BACK) && is_empty) begin
        pend_status_nxt = ST_EMPTY;
      end
      rd_en    = 1'b1;
      rd_addr  = (in_data.opcode == OP_APPEND) ? free_r : head_r;
      cur_nxt  = head_r;
      pred_nxt = NULL_IDX;
    end

    if (cmd.app_link) begin
      // Take the free node, fill it and terminate it.
      new_nxt      = free_r;
      free_nxt     = link_eff;
      wr_link_en   = 1'b1;
      wr_link_addr = free_r;
      wr_link_val  = NULL_IDX;
      wr_data_en   = 1'b1;
      if (head_r >= NULL_IDX) begin
        head_nxt  = free_r;
        count_nxt = count_r + ONE_IDX;
      end else begin
        rd_en   = 1'b1;
        rd_addr = head_r;
      end
    end

    if (cmd.walk) begin
      if (!link_null) begin
        // Step one node further along the chain.
        pred_nxt = cur_r;
        cur_nxt  = link_eff;
        rd_en    = 1'b1;
        rd_addr  = link_eff;
      end else if (op_r == OP_APPEND) begin
        // Tail found: hang the new node behind it.
        wr_link_en   = 1'b1;
        wr_link_addr = cur_r;
        wr_link_val  = new_r;
        count_nxt    = count_r + ONE_IDX;
      end else begin
        // Tail found: return it to the free chain.
        pend_data_nxt = data_q_r;
        wr_link_en    = 1'b1;
        wr_link_addr  = cur_r;
        wr_link_val   = free_r;
        free_nxt      = cur_r;
        count_nxt     = count_r - ONE_IDX;
        if (pred_r >= NULL_IDX) begin
          head_nxt = NULL_IDX;
        end
      end
    end

    if (cmd.back_fix) begin
      // The predecessor becomes the new tail.
      wr_link_en   = 1'b1;
      wr_link_addr = pred_r;
      wr_link_val  = NULL_IDX;
    end

    if (cmd.front) begin
      // Unlink the head and push it onto the free chain.
      pend_data_nxt = data_q_r;
      head_nxt      = link_eff;
      wr_link_en    = 1'b1;
      wr_link_addr  = head_r;
      wr_link_val   = free_r;
      free_nxt      = head_r;
      count_nxt     = count_r - ONE_IDX;
    end
  end

  // The fill mark advances when the first untouched node is written.
  assign fill_nxt = (wr_link_en && (wr_link_addr == fill_r)) ? (fill_r + ONE_IDX) : fill_r;

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.emit) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.data_out = pend_data_r;
      out_data_nxt.status   = pend_status_r;
      out_data_nxt.length   = LEN_W'(count_r);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Memory write and registered read ports.
  always_ff @(posedge clk) begin
    if (wr_link_en) begin
      link_mem[wr_link_addr[AW-1:0]] <= wr_link_val;
    end
    if (wr_data_en) begin
      data_mem[free_r[AW-1:0]] <= byte_r;
    end
    if (rd_en) begin
      link_q_r   <= link_mem[rd_addr[AW-1:0]];
      data_q_r   <= data_mem[rd_addr[AW-1:0]];
      rd_addr_r  <= rd_addr;
      rd_fresh_r <= (rd_addr >= fill_r);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NULL_IDX;
      free_r      <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    cur_r         <= cur_nxt;
    pred_r        <= pred_nxt;
    new_r         <= new_nxt;
    op_r          <= op_nxt;
    byte_r        <= byte_nxt;
    pend_data_r   <= pend_data_nxt;
    pend_status_r <= pend_status_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/alld_ctrl.sv @@
// ----------------------------------------------------------------------------
// alld_ctrl: sequencing state machine for the linked-list byte deque
// Accepts one transaction at a time, steps the datapath through the fetch,
// chain walk and write-back of each operation, then hands off the result.
// ----------------------------------------------------------------------------
module alld_ctrl
  import alld_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_APP_LINK = 3'd1;
  localparam logic [2:0] S_WALK     = 3'd2;
  localparam logic [2:0] S_BACK_FIX = 3'd3;
  localparam logic [2:0] S_FRONT    = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.direct) begin
            state_nxt = S_DONE;
          end else begin
            case (sts.op_in)
              OP_APPEND: state_nxt = S_APP_LINK;
              OP_FRONT:  state_nxt = S_FRONT;
              default:   state_nxt = S_WALK;
            endcase
          end
        end
      end
      S_APP_LINK: begin
        cmd.app_link = 1'b1;
        state_nxt    = sts.head_null ? S_DONE : S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.link_null) begin
          state_nxt = (sts.op_append || sts.pred_null) ? S_DONE : S_BACK_FIX;
        end
      end
      S_BACK_FIX: begin
        cmd.back_fix = 1'b1;
        state_nxt    = S_DONE;
      end
      S_FRONT: begin
        cmd.front = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/array_linked_list_byte_deque_unit.sv @@
// Sequence: an error or the unused opcode goes straight to the result, a front removal unlinks
// the head, and an append to a non-empty list or a back removal walks the list to its tail; a
// back removal on a list of more than one node then makes the predecessor the new tail.
// Throughput: one transaction at a time; the chain walk reads one node per cycle through the
// single read port of the link memory.
// Reset: synchronous, active low; the list comes up empty with every node free at once.
// ----------------------------------------------------------------------------
// array_linked_list_byte_deque_unit: byte deque in an array-backed linked list
// Appends at the back and removes from the front or the back of a singly
// linked list of bytes, with freed nodes kept on a free chain.
// ----------------------------------------------------------------------------
module array_linked_list_byte_deque_unit
  import alld_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  alld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memories, pointers and result register.
  alld_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/alld_checker.sv @@
// ----------------------------------------------------------------------------
// alld_checker: port-level checks for the linked-list byte deque
// Watches the transaction ports of the top level over time and flags
// results that cannot come from a correct list.
// ----------------------------------------------------------------------------
module alld_checker
  import alld_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // One transaction at a time: the input is held off right after an acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An empty error reports an empty list and no byte.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.length == '0 && out_data.data_out == '0)
    else $error("empty status with nonzero length or byte");

  // A full error reports a full list and no byte.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |->
      out_data.length == LEN_W'(DEPTH) && out_data.data_out == '0)
    else $error("full status with wrong length or byte");

  // The status field never carries the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_FULL ||
                  out_data.status == ST_EMPTY)
    else $error("result status out of range");

endmodule

bind array_linked_list_byte_deque_unit alld_checker #(.DEPTH(DEPTH)) u_alld_checker (.*);

@@ tb/array_linked_list_byte_deque_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_linked_list_byte_deque_unit_test: self-checking bench for the byte deque
// Feeds appends, front and back removals and the unused opcode through the
// input channel, predicts every result with an array linked list of its own,
// and checks each result transaction field by field under random idling.
// ----------------------------------------------------------------------------
module array_linked_list_byte_deque_unit_test;
  import alld_pkg::*;

  localparam int NODES       = DEPTH_DEF;
  localparam int NIL         = NODES;
  localparam int RANDOM_OPS  = 1530;
  localparam int CALM_TAIL   = 150;
  localparam int SETTLE      = 100;
  localparam int CYCLE_LIMIT = 1000000;

  // One queued transaction for the driver; drain makes it wait for an empty pipe.
  typedef struct {
    in_item_t item;
    bit       drain;
  } feed_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  feed_t     feed_q[$];
  out_item_t expected_q[$];
  int        owed = 0;
  int        in_gap = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;
  int        accepted = 0;
  int        checked = 0;
  int        full_hits = 0;
  int        empty_hits = 0;
  int        mismatches = 0;
  int        cycle_count = 0;

  // Predicted deque: node bytes, next links, list head, free chain and fill count.
  logic [BYTE_W-1:0] node_byte[NODES];
  int                node_next[NODES];
  int                list_head;
  int                free_top;
  int                fill_count;

  array_linked_list_byte_deque_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Walk the list to its last node; prev gets the node before it, or NIL.
  function automatic int find_last(output int prev);
    int cur;
    int steps;
    cur = list_head;
    prev = NIL;
    steps = 0;
    while (cur < NIL && steps < NODES && node_next[cur] < NIL) begin
      prev = cur;
      cur = node_next[cur];
      steps++;
    end
    return cur;
  endfunction

  // Apply one transaction to the predicted deque and return the result it gives.
  function automatic out_item_t deque_step(in_item_t req);
    out_item_t res;
    int        node;
    int        last;
    int        prev;
    res = '0;
    res.status = ST_OK;
    case (req.opcode)
      OP_APPEND: begin
        if (fill_count >= NODES || free_top >= NIL) begin
          res.status = ST_FULL;
        end else begin
          node = free_top;
          free_top = node_next[node];
          node_byte[node] = req.data_in;
          node_next[node] = NIL;
          if (list_head >= NIL) begin
            list_head = node;
          end else begin
            last = find_last(prev);
            node_next[last] = node;
          end
          fill_count++;
        end
      end
      OP_FRONT: begin
        if (fill_count == 0 || list_head >= NIL) begin
          res.status = ST_EMPTY;
        end else begin
          node = list_head;
          res.data_out = node_byte[node];
          list_head = node_next[node];
          node_next[node] = free_top;
          free_top = node;
          fill_count--;
        end
      end
      OP_BACK: begin
        if (fill_count == 0 || list_head >= NIL) begin
          res.status = ST_EMPTY;
        end else begin
          node = find_last(prev);
          res.data_out = node_byte[node];
          if (prev < NIL) begin
            node_next[prev] = NIL;
          end else begin
            list_head = NIL;
          end
          node_next[node] = free_top;
          free_top = node;
          fill_count--;
        end
      end
      default: begin
      end
    endcase
    res.length = LEN_W'(fill_count);
    return res;
  endfunction

  // Queue one transaction for the driver.
  function automatic void add_op(logic [OP_W-1:0] op, logic [BYTE_W-1:0] value, bit drain);
    feed_t f;
    f.item.opcode = op;
    f.item.data_in = value;
    f.drain = drain;
    feed_q.push_back(f);
  endfunction

  // Pick a random operation for a growing, shrinking or mixed phase.
  function automatic logic [OP_W-1:0] pick_op(int kind);
    int roll;
    roll = $urandom_range(0, 99);
    case (kind)
      0: begin
        return (roll < 85) ? OP_APPEND : (roll < 92) ? OP_FRONT :
               (roll < 98) ? OP_BACK : OP_NONE;
      end
      1: begin
        return (roll < 12) ? OP_APPEND : (roll < 55) ? OP_FRONT :
               (roll < 97) ? OP_BACK : OP_NONE;
      end
      default: begin
        return (roll < 45) ? OP_APPEND : (roll < 70) ? OP_FRONT :
               (roll < 95) ? OP_BACK : OP_NONE;
      end
    endcase
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    int i;
    int made;
    int kind;
    int span;
    int k;

    for (i = 0; i < NODES; i++) begin
      node_next[i] = (i == NODES - 1) ? NIL : i + 1;
    end
    list_head = NIL;
    free_top = 0;
    fill_count = 0;

    // Directed part: empty removals, the unused opcode, byte extremes, single
    // node back removal and walks that need a predecessor.
    add_op(OP_FRONT, 8'h00, 1'b0);
    add_op(OP_BACK, 8'hFF, 1'b0);
    add_op(OP_NONE, 8'hFF, 1'b0);
    add_op(OP_APPEND, 8'h00, 1'b0);
    add_op(OP_BACK, 8'h00, 1'b0);
    add_op(OP_APPEND, 8'hFF, 1'b0);
    add_op(OP_APPEND, 8'h01, 1'b0);
    add_op(OP_NONE, 8'h00, 1'b0);
    add_op(OP_FRONT, 8'h00, 1'b0);
    add_op(OP_BACK, 8'h00, 1'b0);
    add_op(OP_FRONT, 8'h00, 1'b0);
    add_op(OP_APPEND, 8'h80, 1'b1);
    add_op(OP_APPEND, 8'h7F, 1'b0);
    add_op(OP_APPEND, 8'hAA, 1'b0);
    add_op(OP_APPEND, 8'h55, 1'b0);
    add_op(OP_BACK, 8'h00, 1'b0);
    add_op(OP_FRONT, 8'h00, 1'b0);
    add_op(OP_BACK, 8'h00, 1'b0);
    add_op(OP_BACK, 8'h00, 1'b0);
    add_op(OP_BACK, 8'h00, 1'b0);
    add_op(OP_FRONT, 8'h00, 1'b0);

    // Random part: phases that grow the list toward full, shrink it toward empty, or mix.
    made = 0;
    while (made < RANDOM_OPS) begin
      kind = $urandom_range(0, 2);
      span = $urandom_range(10, 130);
      for (k = 0; k < span && made < RANDOM_OPS; k++) begin
        add_op(pick_op(kind), BYTE_W'($urandom_range(0, 255)), (made % 400) == 399);
        made++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || in_valid || owed != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);

    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      mismatches++;
    end
    $display("Checked %0d results for %0d transactions.", checked, accepted);
    $display("Appends on a full list: %0d, removals on an empty list: %0d.",
             full_hits, empty_hits);
    if (mismatches == 0) begin
      $display("PASS array_linked_list_byte_deque_unit");
    end else begin
      $display("FAIL array_linked_list_byte_deque_unit");
    end
    $finish;
  end

  // Driver: presents queued transactions, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      calm <= feed_q.size() < CALM_TAIL;
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (feed_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (feed_q[0].drain && (in_valid || owed != 0)) begin
        // Hold off until every outstanding result has been returned.
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        in_gap <= $urandom_range(1, 14) - 1;
      end else begin
        in_data <= feed_q[0].item;
        in_valid <= 1'b1;
        void'(feed_q.pop_front());
      end
    end
  end

  // Receiver: stalls the result channel in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 14) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts each accepted transaction and checks each result.
  always @(posedge clk) begin
    out_item_t want;
    bit        took;
    bit        gave;
    took = rst_n && in_valid && !in_stall;
    gave = rst_n && out_valid && !out_stall;
    if (took) begin
      want = deque_step(in_data);
      expected_q.push_back(want);
      accepted++;
      if (want.status == ST_FULL) begin
        full_hits++;
      end
      if (want.status == ST_EMPTY) begin
        empty_hits++;
      end
    end
    if (gave) begin
      checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: data_out %0d status %0d length %0d",
               out_data.data_out, out_data.status, out_data.length);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.data_out !== want.data_out) begin
          $error("data_out: expected %0d, actual %0d", want.data_out, out_data.data_out);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, out_data.length);
          mismatches++;
        end
      end
    end
    owed <= owed + int'(took) - int'(gave);
  end

  // Watchdog on the total run time.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles.", cycle_count);
      $display("FAIL array_linked_list_byte_deque_unit");
      $finish;
    end
  end

endmodule

@@ files.f @@
hw/rtl/alld_pkg.sv
hw/rtl/alld_datapath.sv
hw/rtl/alld_ctrl.sv
hw/rtl/array_linked_list_byte_deque_unit.sv
hw/rtl/alld_checker.sv
tb/array_linked_list_byte_deque_unit_test.sv
